### rtl/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared widths, command and status types for the 4x4 adjugate inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int DIM       = 4;
  localparam int NCELL     = DIM * DIM;
  // |2x2| < 2^63, |3x3| < 2^96, |det| < 2^129
  localparam int COF_MAG_W = 96;
  localparam int MAG_W     = 129;
  localparam int ACC_W     = MAG_W + 1;
  localparam int NUM_W     = COF_MAG_W + 2 * FRAC_BITS;
  localparam int DCNT_W    = $clog2(NUM_W + 1);
  localparam int MUL_STEPS = ELEM_W;
  localparam int MCNT_W    = $clog2(MUL_STEPS);

  typedef enum logic [1:0] {
    BSRC_MEM = 2'd0,
    BSRC_P2  = 2'd1,
    BSRC_P3  = 2'd2
  } bsrc_e;

  typedef enum logic [1:0] {
    TGT_P2  = 2'd0,
    TGT_P3  = 2'd1,
    TGT_DET = 2'd2
  } tgt_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              cap_a;
    logic              mul_setup;
    bsrc_e             bsrc;
    logic              mul_step;
    logic              acc_en;
    tgt_e              tgt;
    logic              acc_load;
    logic              acc_neg;
    logic              div_start;
    logic              div_step;
    logic              res_load;
    logic              res_last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } sts_t;

  // index of the x-th remaining row or column once index drop is removed
  function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] drop);
    logic [1:0] r;
    r = (x < drop) ? x : x + 2'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mi4_datapath.sv
// ----------------------------------------------------------------------------
// mi4_datapath
// Element store, shift-add multiply-accumulate unit and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mi4_pkg::cmd_t                 cmd_i,
  input  wire logic [mi4_pkg::ELEM_W-1:0]    wr_data_i,
  output mi4_pkg::sts_t                      sts_o,
  output logic signed [mi4_pkg::ELEM_W-1:0]  res_value_o,
  output logic                               res_singular_o,
  output logic                               res_saturated_o,
  output logic                               res_last_o
);

  localparam int EW = mi4_pkg::ELEM_W;
  localparam int AW = mi4_pkg::ACC_W;
  localparam int MW = mi4_pkg::MAG_W;
  localparam int NW = mi4_pkg::NUM_W;

  logic [EW-1:0] mem_q [mi4_pkg::NCELL];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] opa_q;

  logic [EW-1:0] amag_q;
  logic          sa_q;
  logic [AW-1:0] bsh_q;
  logic [AW-1:0] prod_q;
  logic [AW-1:0] p2_q, p3_q, det_q;

  logic [NW-1:0] num_q;
  logic [MW-1:0] rem_q;
  logic [MW-1:0] dmag_q;
  logic [EW-1:0] quo_q;
  logic          big_q;
  logic          cneg_q, dneg_q;
  logic [mi4_pkg::DCNT_W-1:0] dcnt_q;

  // element store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data_i;
    end
    rd_q <= mem_q[cmd_i.rd_addr];
  end

  // multiply-accumulate
  logic [AW-1:0] bsrc_val;
  logic [AW-1:0] acc_old, acc_term, acc_sum;
  logic          flip;

  always_comb begin
    case (cmd_i.bsrc)
      mi4_pkg::BSRC_MEM: bsrc_val = {{(AW-EW){rd_q[EW-1]}}, rd_q};
      mi4_pkg::BSRC_P2:  bsrc_val = p2_q;
      mi4_pkg::BSRC_P3:  bsrc_val = p3_q;
      default:           bsrc_val = '0;
    endcase
    case (cmd_i.tgt)
      mi4_pkg::TGT_P2:  acc_old = p2_q;
      mi4_pkg::TGT_P3:  acc_old = p3_q;
      mi4_pkg::TGT_DET: acc_old = det_q;
      default:          acc_old = '0;
    endcase
    flip     = cmd_i.acc_neg ^ sa_q;
    acc_term = flip ? (~prod_q + AW'(1)) : prod_q;
    acc_sum  = (cmd_i.acc_load ? '0 : acc_old) + acc_term;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      opa_q <= rd_q;
    end
    if (cmd_i.mul_setup) begin
      sa_q   <= opa_q[EW-1];
      amag_q <= opa_q[EW-1] ? (~opa_q + EW'(1)) : opa_q;
      bsh_q  <= bsrc_val;
      prod_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (amag_q[0]) begin
        prod_q <= prod_q + bsh_q;
      end
      amag_q <= amag_q >> 1;
      bsh_q  <= bsh_q << 1;
    end
    if (cmd_i.acc_en) begin
      case (cmd_i.tgt)
        mi4_pkg::TGT_P2:  p2_q  <= acc_sum;
        mi4_pkg::TGT_P3:  p3_q  <= acc_sum;
        mi4_pkg::TGT_DET: det_q <= acc_sum;
        default:          ;
      endcase
    end
  end

  // restoring division, one quotient bit per cycle while div_step is asserted
  logic [AW-1:0] cof_abs, det_abs;
  logic [MW:0]   rem2, rem2_sub;
  logic          ge;

  always_comb begin
    cof_abs  = p3_q[AW-1] ? (~p3_q + AW'(1)) : p3_q;
    det_abs  = det_q[AW-1] ? (~det_q + AW'(1)) : det_q;
    rem2     = {rem_q, num_q[NW-1]};
    ge       = rem2 >= {1'b0, dmag_q};
    rem2_sub = rem2 - {1'b0, dmag_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= mi4_pkg::DCNT_W'(NW);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= {cof_abs[mi4_pkg::COF_MAG_W-1:0], {(2*mi4_pkg::FRAC_BITS){1'b0}}};
      dmag_q <= det_abs[MW-1:0];
      cneg_q <= p3_q[AW-1];
      dneg_q <= det_q[AW-1];
      rem_q  <= '0;
      quo_q  <= '0;
      big_q  <= 1'b0;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      num_q <= num_q << 1;
      rem_q <= ge ? rem2_sub[MW-1:0] : rem2[MW-1:0];
      quo_q <= {quo_q[EW-2:0], ge};
      big_q <= big_q | quo_q[EW-1];
    end
  end

  // result register
  logic          det_zero;
  logic          rneg, rsat;
  logic [EW-1:0] rval;

  always_comb begin
    det_zero = (det_q == '0);
    rneg     = cneg_q ^ dneg_q;
    if (rneg) begin
      rsat = big_q | (quo_q[EW-1] & (quo_q[EW-2:0] != '0));
      rval = rsat ? {1'b1, {(EW-1){1'b0}}} : (~quo_q + EW'(1));
    end else begin
      rsat = big_q | quo_q[EW-1];
      rval = rsat ? {1'b0, {(EW-1){1'b1}}} : quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_value_o     <= det_zero ? '0 : $signed(rval);
      res_singular_o  <= det_zero;
      res_saturated_o <= det_zero ? 1'b0 : rsat;
      res_last_o      <= cmd_i.res_last;
    end
  end

  assign sts_o = {det_zero, (dcnt_q == '0)};

endmodule

`default_nettype wire

### rtl/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: loads elements, walks the cofactor expansion and the divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mi4_pkg::sts_t sts_i,
  output mi4_pkg::cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_LOAD = 9'b0_0000_0001,
    S_RDA  = 9'b0_0000_0010,
    S_RDB  = 9'b0_0000_0100,
    S_MLD  = 9'b0_0000_1000,
    S_MUL  = 9'b0_0001_0000,
    S_ACC  = 9'b0_0010_0000,
    S_DIV  = 9'b0_0100_0000,
    S_RES  = 9'b0_1000_0000,
    S_DST  = 9'b1_0000_0000
  } state_e;

  localparam logic [3:0] STEP_LAST_MINOR = 4'd8;
  localparam logic [3:0] STEP_DET        = 4'd9;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_ph_q, out_ph_d;
  logic [1:0] n_q, n_d;
  logic [3:0] k_q, k_d;
  logic [3:0] s_q, s_d;
  logic [mi4_pkg::MCNT_W-1:0] mcnt_q, mcnt_d;

  logic [1:0] row_drop, col_drop, t, m;
  logic       det_step;
  logic [1:0] ca, cb;
  logic [3:0] addr_a, addr_b;
  logic       load_f, neg_f;
  mi4_pkg::bsrc_e bsrc;
  mi4_pkg::tgt_e  tgt;

  // step decode: three products per term, three terms, then the det term
  always_comb begin
    det_step = 1'b0;
    case (s_q)
      4'd0:    begin t = 2'd0; m = 2'd0; end
      4'd1:    begin t = 2'd0; m = 2'd1; end
      4'd2:    begin t = 2'd0; m = 2'd2; end
      4'd3:    begin t = 2'd1; m = 2'd0; end
      4'd4:    begin t = 2'd1; m = 2'd1; end
      4'd5:    begin t = 2'd1; m = 2'd2; end
      4'd6:    begin t = 2'd2; m = 2'd0; end
      4'd7:    begin t = 2'd2; m = 2'd1; end
      4'd8:    begin t = 2'd2; m = 2'd2; end
      default: begin t = 2'd0; m = 2'd0; det_step = 1'b1; end
    endcase
    row_drop = out_ph_q ? k_q[1:0] : n_q;
    col_drop = out_ph_q ? k_q[3:2] : 2'd0;
    ca = (t == 2'd0) ? 2'd1 : 2'd0;
    cb = (t == 2'd2) ? 2'd1 : 2'd2;
    if (det_step) begin
      addr_a = {n_q, 2'd0};
      addr_b = '0;
      bsrc   = mi4_pkg::BSRC_P3;
      tgt    = mi4_pkg::TGT_DET;
      load_f = (n_q == 2'd0);
      neg_f  = 1'b0;
    end else if (m == 2'd0) begin
      addr_a = {mi4_pkg::skip_idx(2'd1, row_drop), mi4_pkg::skip_idx(ca, col_drop)};
      addr_b = {mi4_pkg::skip_idx(2'd2, row_drop), mi4_pkg::skip_idx(cb, col_drop)};
      bsrc   = mi4_pkg::BSRC_MEM;
      tgt    = mi4_pkg::TGT_P2;
      load_f = 1'b1;
      neg_f  = 1'b0;
    end else if (m == 2'd1) begin
      addr_a = {mi4_pkg::skip_idx(2'd2, row_drop), mi4_pkg::skip_idx(ca, col_drop)};
      addr_b = {mi4_pkg::skip_idx(2'd1, row_drop), mi4_pkg::skip_idx(cb, col_drop)};
      bsrc   = mi4_pkg::BSRC_MEM;
      tgt    = mi4_pkg::TGT_P2;
      load_f = 1'b0;
      neg_f  = 1'b1;
    end else begin
      addr_a = {mi4_pkg::skip_idx(2'd0, row_drop), mi4_pkg::skip_idx(t, col_drop)};
      addr_b = '0;
      bsrc   = mi4_pkg::BSRC_P2;
      tgt    = mi4_pkg::TGT_P3;
      load_f = (t == 2'd0);
      // checkerboard sign of the cofactor folded in here
      neg_f  = (t == 2'd1) ^ row_drop[0] ^ col_drop[0];
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_ph_d = out_ph_q;
    n_d      = n_q;
    k_d      = k_q;
    s_d      = s_q;
    mcnt_d   = mcnt_q;

    cmd_o           = '0;
    cmd_o.wr_addr   = cnt_q;
    cmd_o.rd_addr   = (state_q == S_RDB) ? addr_b : addr_a;
    cmd_o.bsrc      = bsrc;
    cmd_o.tgt       = tgt;
    cmd_o.acc_load  = load_f;
    cmd_o.acc_neg   = neg_f;
    cmd_o.res_last  = (k_q == 4'd15);

    in_ready_o  = (state_q == S_LOAD);
    out_valid_o = (state_q == S_RES);

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (cnt_q == 4'd15) begin
            cnt_d    = '0;
            out_ph_d = 1'b0;
            n_d      = '0;
            k_d      = '0;
            s_d      = '0;
            state_d  = S_RDA;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      S_RDA: state_d = S_RDB;
      S_RDB: begin
        cmd_o.cap_a = 1'b1;
        state_d     = S_MLD;
      end
      S_MLD: begin
        cmd_o.mul_setup = 1'b1;
        mcnt_d          = '0;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        mcnt_d         = mcnt_q + 1'b1;
        if (mcnt_q == mi4_pkg::MCNT_W'(mi4_pkg::MUL_STEPS - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_RDA;
        if (!out_ph_q) begin
          if (s_q == STEP_DET) begin
            s_d = '0;
            if (n_q == 2'd3) begin
              out_ph_d = 1'b1;
            end else begin
              n_d = n_q + 2'd1;
            end
          end else begin
            s_d = s_q + 4'd1;
          end
        end else if (s_q == STEP_LAST_MINOR) begin
          if (sts_i.det_zero) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_RES;
          end else begin
            // cofactor lands in p3 at this edge, start the divider next cycle
            state_d = S_DST;
          end
        end else begin
          s_d = s_q + 4'd1;
        end
      end
      S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_RES;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_RES: begin
        if (out_ready_i) begin
          if (k_q == 4'd15) begin
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + 4'd1;
            s_d     = '0;
            state_d = S_RDA;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      out_ph_q <= 1'b0;
      n_q      <= '0;
      k_q      <= '0;
      s_q      <= '0;
      mcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      out_ph_q <= out_ph_d;
      n_q      <= n_d;
      k_q      <= k_d;
      s_q      <= s_d;
      mcnt_q   <= mcnt_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_div_nonsingular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !sts_i.det_zero)
    else $error("division started on a singular matrix");

  a_last_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && k_q == 4'd15) |=> in_ready_o)
    else $error("no return to loading after last beat");

  a_results_only_in_out_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_ph_q)
    else $error("result presented before the determinant is done");

endmodule

`default_nettype wire

### rtl/matrix_inverse_4x4.sv
// each multiply-accumulate is one 32-step shift-add pass; the determinant takes
//   40 of them, then each result takes 9 for its cofactor plus, unless the
//   determinant is zero, one divider pass (start, 128 steps, finish)
// throughput: one matrix at a time; 16 input beats are taken only while idle
// reset: asynchronous, active low; clears the load count and the sequencer
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 fixed-point inverse by the adjugate, with singular and saturation flags.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_4x4 (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [mi4_pkg::ELEM_W-1:0] element_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [mi4_pkg::ELEM_W-1:0]      inverse_element_o,
  output logic                                   singular_o,
  output logic                                   saturated_o,
  output logic                                   last_of_matrix_o
);

  mi4_pkg::cmd_t cmd;
  mi4_pkg::sts_t sts;

  mi4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mi4_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .wr_data_i       (element_value_i),
    .sts_o           (sts),
    .res_value_o     (inverse_element_o),
    .res_singular_o  (singular_o),
    .res_saturated_o (saturated_o),
    .res_last_o      (last_of_matrix_o)
  );

endmodule

`default_nettype wire
